>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/gha_pkg.sv
package gha_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int FUNC_W    = 2;
    localparam int REG_W     = 32;
    localparam int IDX_W     = 10;
    localparam int GEN_W     = 32;
    localparam int ACNT_W    = 11;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CREATE    = 2'd0,
        FUNC_DESTROY   = 2'd1,
        FUNC_QUERY     = 2'd2,
        FUNC_RESET_ALL = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_ALIVE = 2'd1,
        STS_NO_FREE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_SWEEP
    } t_state;

    localparam logic REG_IDX_REGISTRY = 1'b0;

    typedef struct packed {
        t_func              func;
        logic [REG_W-1:0]   handle_registry;
        logic [IDX_W-1:0]   handle_index;
        logic [GEN_W-1:0]   handle_generation;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   out_index;
        logic [GEN_W-1:0]   out_generation;
        logic               alive_flag;
        logic [ACNT_W-1:0]  alive_count;
    } t_result;

    typedef struct packed {
        logic accept;
        logic access;
        logic sweep_step;
        logic sweep_done;
    } t_ctl;

    typedef struct packed {
        logic req_reset;
        logic ptr_zero;
    } t_sts;

endpackage

>>> src/gha_ram.sv
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/gha_ctrl.sv
module gha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gha_pkg::t_sts i_sts,
    output gha_pkg::t_ctl o_ctl,
    output logic          o_busy
);

    gha_pkg::t_state r_state;
    gha_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = (r_state != gha_pkg::S_IDLE);
        case (r_state)
            gha_pkg::S_IDLE: begin
                if (i_start) begin
                    o_ctl.accept = 1'b1;
                    n_state = i_sts.req_reset ? gha_pkg::S_SWEEP : gha_pkg::S_ACCESS;
                end
            end
            gha_pkg::S_ACCESS: begin
                o_ctl.access = 1'b1;
                n_state = gha_pkg::S_IDLE;
            end
            gha_pkg::S_SWEEP: begin
                o_ctl.sweep_step = 1'b1;
                if (i_sts.ptr_zero) begin
                    o_ctl.sweep_done = 1'b1;
                    n_state = gha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> src/gha_dpath.sv
module gha_dpath #(
    parameter int SLOTS = gha_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gha_pkg::t_ctl               i_ctl,
    input  gha_pkg::t_cmd               i_cmd,
    input  logic [gha_pkg::REG_W-1:0]   i_registry,
    output gha_pkg::t_sts               o_sts,
    output gha_pkg::t_result            o_result,
    output logic                        o_done
);

    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int GW    = gha_pkg::GEN_W;
    localparam int EW    = 1 + GW + CW;
    localparam int XW    = gha_pkg::IDX_W;
    localparam int AW    = gha_pkg::ACNT_W;
    localparam int CMPW  = (CW > XW) ? CW : XW;
    localparam logic [CW-1:0] NONE = CW'(SLOTS);

    function automatic logic [GW-1:0] next_gen(input logic [GW-1:0] g);
        logic [GW-1:0] s;
        s = g + 1'b1;
        if (s == '0) begin
            s = GW'(1);
        end
        return s;
    endfunction

    logic [CW-1:0]        r_free_head, n_free_head;
    logic [CW-1:0]        r_siu, n_siu;
    logic [CW-1:0]        r_live, n_live;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic                 r_wr_pend, n_wr_pend;
    logic [IW-1:0]        r_wr_idx, n_wr_idx;
    gha_pkg::t_func       r_op, n_op;
    logic [IW-1:0]        r_idx, n_idx;
    logic [GW-1:0]        r_gen, n_gen;
    logic                 r_reg_ok, n_reg_ok;
    logic                 r_pop, n_pop;
    gha_pkg::t_result     r_result, n_result;
    logic                 r_done, n_done;

    logic                 ram_we, ram_re;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    logic [EW-1:0]        ram_wdata, ram_rdata;

    logic                 rd_alive;
    logic [GW-1:0]        rd_gen;
    logic [CW-1:0]        rd_link;
    logic                 head_valid;
    logic                 live_hit;
    gha_pkg::t_result     res;

    gha_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        rd_alive   = ram_rdata[EW-1];
        rd_gen     = ram_rdata[EW-2 -: GW];
        rd_link    = ram_rdata[CW-1:0];
        head_valid = (r_free_head < NONE);
        live_hit   = r_reg_ok && rd_alive && (rd_gen == r_gen);

        o_sts.req_reset = (i_cmd.func == gha_pkg::FUNC_RESET_ALL);
        o_sts.ptr_zero  = (r_ptr == '0);

        n_free_head = r_free_head;
        n_siu       = r_siu;
        n_live      = r_live;
        n_ptr       = r_ptr;
        n_wr_pend   = r_wr_pend;
        n_wr_idx    = r_wr_idx;
        n_op        = r_op;
        n_idx       = r_idx;
        n_gen       = r_gen;
        n_reg_ok    = r_reg_ok;
        n_pop       = r_pop;
        n_result    = r_result;
        n_done      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        res         = '0;

        if (i_ctl.accept) begin
            n_op     = i_cmd.func;
            n_idx    = IW'(i_cmd.handle_index);
            n_gen    = i_cmd.handle_generation;
            n_reg_ok = (i_cmd.handle_registry != '0)
                    && (i_cmd.handle_registry == i_registry)
                    && (CMPW'(i_cmd.handle_index) < CMPW'(r_siu));
            n_pop    = head_valid;
            case (i_cmd.func)
                gha_pkg::FUNC_CREATE: begin
                    ram_re    = head_valid;
                    ram_raddr = r_free_head[IW-1:0];
                end
                gha_pkg::FUNC_DESTROY, gha_pkg::FUNC_QUERY: begin
                    ram_re    = 1'b1;
                    ram_raddr = IW'(i_cmd.handle_index);
                end
                gha_pkg::FUNC_RESET_ALL: begin
                    n_free_head = NONE;
                    n_live      = '0;
                    n_ptr       = r_siu;
                    n_wr_pend   = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (i_ctl.access) begin
            res.status = gha_pkg::STS_OK;
            case (r_op)
                gha_pkg::FUNC_CREATE: begin
                    if (r_pop) begin
                        ram_we             = 1'b1;
                        ram_waddr          = r_free_head[IW-1:0];
                        ram_wdata          = {1'b1, rd_gen, NONE};
                        n_free_head        = (rd_link < NONE) ? rd_link : NONE;
                        n_live             = CW'(r_live + 1'b1);
                        res.out_index      = XW'(r_free_head);
                        res.out_generation = rd_gen;
                    end else if (r_siu < NONE) begin
                        ram_we             = 1'b1;
                        ram_waddr          = r_siu[IW-1:0];
                        ram_wdata          = {1'b1, GW'(1), NONE};
                        n_siu              = CW'(r_siu + 1'b1);
                        n_live             = CW'(r_live + 1'b1);
                        res.out_index      = XW'(r_siu);
                        res.out_generation = GW'(1);
                    end else begin
                        res.status = gha_pkg::STS_NO_FREE;
                    end
                end
                gha_pkg::FUNC_DESTROY: begin
                    res.alive_flag = live_hit;
                    if (live_hit) begin
                        ram_we      = 1'b1;
                        ram_waddr   = r_idx;
                        ram_wdata   = {1'b0, next_gen(rd_gen), r_free_head};
                        n_free_head = CW'(r_idx);
                        if (r_live != '0) begin
                            n_live = CW'(r_live - 1'b1);
                        end
                    end else begin
                        res.status = gha_pkg::STS_NOT_ALIVE;
                    end
                end
                gha_pkg::FUNC_QUERY: begin
                    res.alive_flag = live_hit;
                end
                default: begin
                end
            endcase
            res.alive_count = AW'(n_live);
            n_result = res;
            n_done   = 1'b1;
        end

        if (i_ctl.sweep_step) begin
            if (r_wr_pend) begin
                ram_we      = 1'b1;
                ram_waddr   = r_wr_idx;
                ram_wdata   = {1'b0, rd_alive ? next_gen(rd_gen) : rd_gen, r_free_head};
                n_free_head = CW'(r_wr_idx);
            end
            if (r_ptr != '0) begin
                ram_re    = 1'b1;
                ram_raddr = IW'(r_ptr - 1'b1);
                n_ptr     = CW'(r_ptr - 1'b1);
                n_wr_pend = 1'b1;
                n_wr_idx  = IW'(r_ptr - 1'b1);
            end else begin
                n_wr_pend = 1'b0;
            end
        end

        if (i_ctl.sweep_done) begin
            res             = '0;
            res.status      = gha_pkg::STS_OK;
            res.alive_count = AW'(n_live);
            n_result        = res;
            n_done          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= NONE;
            r_siu       <= '0;
            r_live      <= '0;
            r_ptr       <= '0;
            r_wr_pend   <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_free_head <= n_free_head;
            r_siu       <= n_siu;
            r_live      <= n_live;
            r_ptr       <= n_ptr;
            r_wr_pend   <= n_wr_pend;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_idx <= n_wr_idx;
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_gen    <= n_gen;
        r_reg_ok <= n_reg_ok;
        r_pop    <= n_pop;
        r_result <= n_result;
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

>>> src/generational_handle_allocator.sv
// Channel   | Ports                                   | Transfer
// ----------+-----------------------------------------+---------------------------------
// command   | start, busy, i_cmd                      | edge with start high, busy low
// result    | o_done, o_result                        | edge ending the o_done cycle
// config    | psel, penable, pwrite, paddr, pwdata,   | edge with psel, penable, pwrite,
//           | prdata, pready                          | pready high; registry_id at 0x0
//
// Create, destroy and query do one slot-memory read, then compare and, for create and destroy, write.
// Reset all walks every used slot, one slot per cycle through the read/write ports.
// The result strobe rises the cycle after the last work cycle; busy is then already low.
// Synchronous reset clears the free list, slot and live counts; registry_id resets to 1.
// Results are never stalled; o_done lasts one cycle.
`include "assert_macros.svh"

module generational_handle_allocator #(
    parameter int SLOTS = gha_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gha_pkg::t_cmd                 i_cmd,
    output logic                          o_done,
    output gha_pkg::t_result              o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gha_pkg::APB_AW-1:0]    paddr,
    input  logic [gha_pkg::APB_DW-1:0]    pwdata,
    output logic [gha_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    gha_pkg::t_ctl              ctl;
    gha_pkg::t_sts              sts;
    logic [gha_pkg::REG_W-1:0]  r_registry;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_registry <= gha_pkg::REG_W'(1);
        end else if (cfg_wr && (paddr[2] == gha_pkg::REG_IDX_REGISTRY)) begin
            r_registry <= pwdata;
        end
    end

    assign prdata = (paddr[2] == gha_pkg::REG_IDX_REGISTRY) ? r_registry : '0;

    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    gha_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_cmd      (i_cmd),
        .i_registry (r_registry),
        .o_sts      (sts),
        .o_result   (o_result),
        .o_done     (o_done)
    );

    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept did not raise busy")
    `ASSERT_CLK(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "result strobe while busy")
    `ASSERT_CLK(a_done_after_busy, i_clk, i_rst_n, o_done |-> $past(busy), "result without work")
    `ASSERT_CLK_NR(a_reset_quiet, i_clk, !i_rst_n |=> (!o_done && !busy), "activity after reset")

endmodule

>>> tb/tb_generational_handle_allocator.sv
`timescale 1ns / 1ps

module tb_generational_handle_allocator;

    localparam int SLOTS = gha_pkg::SLOTS_DEF;

    typedef struct packed {
        logic [gha_pkg::IDX_W-1:0] idx;
        logic [gha_pkg::GEN_W-1:0] gen;
    } t_slot_ref;

    class handle_tracker;
        logic [gha_pkg::REG_W-1:0] registry_id;
        bit [gha_pkg::GEN_W-1:0]   gen_tab[SLOTS];
        bit                        alive_tab[SLOTS];
        int unsigned               link_tab[SLOTS];
        int unsigned               free_head;
        int unsigned               used;
        int unsigned               live;
        gha_pkg::t_result          pending[$];
        t_slot_ref                 live_slots[$];
        t_slot_ref                 stale_slots[$];
        int                        errors;

        function new();
            registry_id = 1;
            free_head   = SLOTS;
            used        = 0;
            live        = 0;
            errors      = 0;
        endfunction

        function bit [gha_pkg::GEN_W-1:0] bump_generation(bit [gha_pkg::GEN_W-1:0] g);
            bit [gha_pkg::GEN_W-1:0] n;
            n = g + 1'b1;
            return (n == 0) ? 1 : n;
        endfunction

        function bit is_alive(gha_pkg::t_cmd c);
            return c.handle_registry != 0 && c.handle_registry == registry_id
                && c.handle_index < used && alive_tab[c.handle_index]
                && gen_tab[c.handle_index] == c.handle_generation;
        endfunction

        function void retire(t_slot_ref s);
            stale_slots.push_back(s);
            if (stale_slots.size() > 32) void'(stale_slots.pop_front());
        endfunction

        function void accept_command(gha_pkg::t_cmd c);
            gha_pkg::t_result e;
            int unsigned      s;
            int unsigned      k;
            int               q;
            bit               got;
            e = '0;
            case (c.func)
                gha_pkg::FUNC_CREATE: begin
                    got = 1'b1;
                    if (free_head < SLOTS) begin
                        s = free_head;
                        free_head = link_tab[s];
                        if (free_head >= SLOTS) free_head = SLOTS;
                        link_tab[s] = SLOTS;
                    end else if (used < SLOTS) begin
                        s = used;
                        used++;
                        gen_tab[s] = 1;
                        link_tab[s] = SLOTS;
                    end else begin
                        got = 1'b0;
                        e.status = gha_pkg::STS_NO_FREE;
                    end
                    if (got) begin
                        alive_tab[s] = 1'b1;
                        live++;
                        e.out_index = gha_pkg::IDX_W'(s);
                        e.out_generation = gen_tab[s];
                        live_slots.push_back('{idx: gha_pkg::IDX_W'(s), gen: gen_tab[s]});
                    end
                end
                gha_pkg::FUNC_DESTROY: begin
                    if (is_alive(c)) begin
                        k = c.handle_index;
                        e.alive_flag = 1'b1;
                        q = -1;
                        foreach (live_slots[i]) if (live_slots[i].idx == k) q = i;
                        if (q >= 0) begin
                            retire(live_slots[q]);
                            live_slots.delete(q);
                        end
                        alive_tab[k] = 1'b0;
                        gen_tab[k] = bump_generation(gen_tab[k]);
                        link_tab[k] = free_head;
                        free_head = k;
                        if (live > 0) live--;
                    end else begin
                        e.status = gha_pkg::STS_NOT_ALIVE;
                    end
                end
                gha_pkg::FUNC_QUERY: begin
                    e.alive_flag = is_alive(c);
                end
                default: begin
                    free_head = SLOTS;
                    live = 0;
                    for (int i = used; i > 0; i--) begin
                        k = i - 1;
                        if (alive_tab[k]) gen_tab[k] = bump_generation(gen_tab[k]);
                        alive_tab[k] = 1'b0;
                        link_tab[k] = free_head;
                        free_head = k;
                    end
                    foreach (live_slots[i]) retire(live_slots[i]);
                    live_slots.delete();
                end
            endcase
            e.alive_count = gha_pkg::ACNT_W'(live);
            pending.push_back(e);
        endfunction

        function void compare_field(string name, logic [63:0] e, logic [63:0] g);
            if (g !== e) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, e, g);
                errors++;
            end
        endfunction

        function void check_result(gha_pkg::t_result got);
            gha_pkg::t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result expected none actual %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            compare_field("status", e.status, got.status);
            compare_field("out_index", e.out_index, got.out_index);
            compare_field("out_generation", e.out_generation, got.out_generation);
            compare_field("alive_flag", e.alive_flag, got.alive_flag);
            compare_field("alive_count", e.alive_count, got.alive_count);
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    gha_pkg::t_cmd                cmd_drv;
    logic                         o_done;
    gha_pkg::t_result             result_mon;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [gha_pkg::APB_AW-1:0]   paddr;
    logic [gha_pkg::APB_DW-1:0]   pwdata;
    logic [gha_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    handle_tracker tracker;
    int            gap_pct;

    generational_handle_allocator #(.SLOTS(SLOTS)) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd_drv),
        .o_done   (o_done),
        .o_result (result_mon),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) tracker.check_result(result_mon);
    end

    initial begin
        #2000000;
        $display("[generational_handle_allocator] ERROR");
        $finish;
    end

    task automatic push_command(gha_pkg::t_cmd c);
        start   <= 1'b1;
        cmd_drv <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.accept_command(c);
        @(negedge i_clk);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic send_op(gha_pkg::t_func f, logic [gha_pkg::REG_W-1:0] r,
                           logic [gha_pkg::IDX_W-1:0] x, logic [gha_pkg::GEN_W-1:0] g);
        gha_pkg::t_cmd c;
        c.func              = f;
        c.handle_registry   = r;
        c.handle_index      = x;
        c.handle_generation = g;
        push_command(c);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (tracker.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_registry(logic [gha_pkg::APB_DW-1:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= gha_pkg::APB_AW'(4 * gha_pkg::REG_IDX_REGISTRY);
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        tracker.registry_id = v;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== v) begin
            $display("%0t: registry_id readback expected %0h actual %0h", $time, v, prdata);
            tracker.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic gha_pkg::t_cmd pick_command();
        gha_pkg::t_cmd c;
        t_slot_ref     h;
        int unsigned   r;
        c.func              = gha_pkg::FUNC_CREATE;
        c.handle_registry   = $urandom();
        c.handle_index      = gha_pkg::IDX_W'($urandom());
        c.handle_generation = $urandom();
        r = $urandom_range(99);
        if (r < 35) return c;
        c.func = $urandom_range(1) ? gha_pkg::FUNC_DESTROY : gha_pkg::FUNC_QUERY;
        if (r >= 98) begin
            c.func = gha_pkg::FUNC_RESET_ALL;
        end else if (r < 75 && tracker.live_slots.size() > 0) begin
            h = tracker.live_slots[$urandom_range(tracker.live_slots.size() - 1)];
            c.handle_registry   = tracker.registry_id;
            c.handle_index      = h.idx;
            c.handle_generation = h.gen;
        end else if (r < 82 && tracker.stale_slots.size() > 0) begin
            h = tracker.stale_slots[$urandom_range(tracker.stale_slots.size() - 1)];
            c.handle_registry   = tracker.registry_id;
            c.handle_index      = h.idx;
            c.handle_generation = h.gen;
        end else if (r < 90 && tracker.live_slots.size() > 0) begin
            h = tracker.live_slots[$urandom_range(tracker.live_slots.size() - 1)];
            c.handle_registry   = tracker.registry_id;
            c.handle_index      = h.idx;
            c.handle_generation = h.gen;
            case ($urandom_range(3))
                0: c.handle_registry = '0;
                1: c.handle_registry = c.handle_registry
                       ^ (gha_pkg::REG_W'(1) << $urandom_range(gha_pkg::REG_W - 1));
                2: c.handle_generation = c.handle_generation
                       ^ (gha_pkg::GEN_W'(1) << $urandom_range(gha_pkg::GEN_W - 1));
                default: c.handle_index = c.handle_index
                       ^ (gha_pkg::IDX_W'(1) << $urandom_range(gha_pkg::IDX_W - 1));
            endcase
        end else if ($urandom_range(1) && tracker.used > 0) begin
            c.handle_index = gha_pkg::IDX_W'($urandom_range(tracker.used - 1));
        end
        return c;
    endfunction

    initial begin
        int                          gap_plan[4];
        logic [gha_pkg::REG_W-1:0]   rid;
        logic [gha_pkg::APB_DW-1:0]  v;
        gap_plan = '{0, 68, 0, 26};
        tracker  = new();
        gap_pct  = 0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        cmd_drv  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        rid = tracker.registry_id;
        send_op(gha_pkg::FUNC_CREATE, '0, '0, '0);
        send_op(gha_pkg::FUNC_CREATE, '1, '1, '1);
        send_op(gha_pkg::FUNC_CREATE, '0, '1, '0);
        send_op(gha_pkg::FUNC_QUERY, rid, 0, 1);
        send_op(gha_pkg::FUNC_DESTROY, rid, 1, 1);
        send_op(gha_pkg::FUNC_DESTROY, rid, 1, 1);
        send_op(gha_pkg::FUNC_QUERY, rid, 1, 1);
        send_op(gha_pkg::FUNC_CREATE, '1, '1, '1);
        send_op(gha_pkg::FUNC_QUERY, '0, 0, 1);
        send_op(gha_pkg::FUNC_QUERY, '1, 0, 1);
        send_op(gha_pkg::FUNC_QUERY, rid, 0, '1);
        send_op(gha_pkg::FUNC_QUERY, rid, 0, '0);
        send_op(gha_pkg::FUNC_QUERY, rid, '1, 1);
        send_op(gha_pkg::FUNC_DESTROY, rid, 3, 1);
        send_op(gha_pkg::FUNC_DESTROY, rid, 2, 1);
        send_op(gha_pkg::FUNC_RESET_ALL, '1, '1, '1);
        send_op(gha_pkg::FUNC_QUERY, rid, 0, 1);
        send_op(gha_pkg::FUNC_CREATE, '0, '0, '0);
        send_op(gha_pkg::FUNC_CREATE, '0, '0, '0);
        send_op(gha_pkg::FUNC_CREATE, '0, '0, '0);
        send_op(gha_pkg::FUNC_CREATE, '0, '0, '0);
        send_op(gha_pkg::FUNC_QUERY, rid, 1, 3);
        send_op(gha_pkg::FUNC_RESET_ALL, '0, '0, '0);

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            case (p)
                0:       v = 32'hFFFF_FFFF;
                2:       v = 32'd1;
                default: v = $urandom_range(32'hFFFF_FFFF, 1);
            endcase
            write_registry(v);
            gap_pct = gap_plan[p % 4];
            repeat (85) push_command(pick_command());
        end

        wait_idle();
        write_registry($urandom_range(32'hFFFF_FFFF, 1));
        gap_pct = 26;
        while (tracker.free_head < SLOTS || tracker.used < SLOTS)
            send_op(gha_pkg::FUNC_CREATE, $urandom(), $urandom(), $urandom());
        repeat (3) send_op(gha_pkg::FUNC_CREATE, $urandom(), $urandom(), $urandom());
        gap_pct = 68;
        repeat (150) push_command(pick_command());

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("[generational_handle_allocator] OK");
        end else begin
            $display("[generational_handle_allocator] ERROR");
        end
        $finish;
    end

endmodule
